// ----- rtl/kbsc_pkg.sv -----
// ---------------------------------------------------------------------------
// kbsc_pkg
// Shared codes, types and key tables for the set-1 scan code decoder.
// ---------------------------------------------------------------------------
package kbsc_pkg;

   localparam int unsigned CODE_W = 8;
   localparam int unsigned CHAR_W = 7;

   // Scan codes with a fixed meaning (make codes unless noted)
   localparam logic [CODE_W-1:0] SC_EXT_PREFIX    = 8'hE0;
   localparam logic [CODE_W-1:0] SC_PAUSE_PREFIX  = 8'hE1;
   localparam logic [CODE_W-1:0] SC_CTRL_MAKE     = 8'h1D;
   localparam logic [CODE_W-1:0] SC_CTRL_BREAK    = 8'h9D;
   localparam logic [CODE_W-1:0] SC_LSHIFT_MAKE   = 8'h2A;
   localparam logic [CODE_W-1:0] SC_RSHIFT_MAKE   = 8'h36;
   localparam logic [CODE_W-1:0] SC_LSHIFT_BREAK  = 8'hAA;
   localparam logic [CODE_W-1:0] SC_RSHIFT_BREAK  = 8'hB6;
   localparam logic [CODE_W-1:0] SC_ALT_MAKE      = 8'h38;
   localparam logic [CODE_W-1:0] SC_ALT_BREAK     = 8'hB8;
   localparam logic [CODE_W-1:0] SC_DEL_MAKE      = 8'h53;
   localparam logic [CODE_W-1:0] SC_DEL_BREAK     = 8'hD3;
   localparam logic [CODE_W-1:0] SC_NUMLOCK_MAKE  = 8'h45;
   localparam logic [CODE_W-1:0] SC_NUMLOCK_BREAK = 8'hC5;
   localparam logic [CODE_W-1:0] SC_ESCAPE        = 8'h01;
   localparam logic [CODE_W-1:0] SC_BACKSPACE     = 8'h0E;
   localparam logic [CODE_W-1:0] SC_TAB           = 8'h0F;
   localparam logic [CODE_W-1:0] SC_ENTER         = 8'h1C;
   localparam logic [CODE_W-1:0] SC_SPACE         = 8'h39;

   localparam logic [2:0] PAUSE_TAIL_LEN = 3'd5;

   typedef struct packed {
      logic ctrl;
      logic shift;
   } kbsc_mods_type;

   typedef struct packed {
      logic              present;
      logic [CHAR_W-1:0] plain;
      logic [CHAR_W-1:0] shifted;
      logic              ctrl_ok;
      logic [CHAR_W-1:0] ctrl_char;
   } kbsc_sym_type;

   // Expected byte of the pause sequence tail, indexed from 1
   function automatic logic [CODE_W-1:0] pause_byte(input logic [2:0] idx);
      logic [CODE_W-1:0] b;
      unique case (idx)
         3'd1:    b = SC_CTRL_MAKE;
         3'd2:    b = SC_NUMLOCK_MAKE;
         3'd3:    b = SC_PAUSE_PREFIX;
         3'd4:    b = SC_CTRL_BREAK;
         3'd5:    b = SC_NUMLOCK_BREAK;
         default: b = '0;
      endcase
      return b;
   endfunction

   // Lowercase letter for codes 0x00..0x3F, zero when not a letter key
   function automatic logic [CHAR_W-1:0] letter_of(input logic [5:0] idx);
      logic [CHAR_W-1:0] l;
      unique case (idx)
         6'h10: l = 7'h71;
         6'h11: l = 7'h77;
         6'h12: l = 7'h65;
         6'h13: l = 7'h72;
         6'h14: l = 7'h74;
         6'h15: l = 7'h79;
         6'h16: l = 7'h75;
         6'h17: l = 7'h69;
         6'h18: l = 7'h6F;
         6'h19: l = 7'h70;
         6'h1E: l = 7'h61;
         6'h1F: l = 7'h73;
         6'h20: l = 7'h64;
         6'h21: l = 7'h66;
         6'h22: l = 7'h67;
         6'h23: l = 7'h68;
         6'h24: l = 7'h6A;
         6'h25: l = 7'h6B;
         6'h26: l = 7'h6C;
         6'h2C: l = 7'h7A;
         6'h2D: l = 7'h78;
         6'h2E: l = 7'h63;
         6'h2F: l = 7'h76;
         6'h30: l = 7'h62;
         6'h31: l = 7'h6E;
         6'h32: l = 7'h6D;
         default: l = '0;
      endcase
      return l;
   endfunction

   // Digit and punctuation keys: plain, shifted and ctrl forms
   function automatic kbsc_sym_type symbol_of(input logic [5:0] idx);
      kbsc_sym_type s;
      unique case (idx)
         6'h02: s = '{1'b1, 7'h31, 7'h21, 1'b0, 7'h00};
         6'h03: s = '{1'b1, 7'h32, 7'h40, 1'b1, 7'h00};
         6'h04: s = '{1'b1, 7'h33, 7'h23, 1'b0, 7'h00};
         6'h05: s = '{1'b1, 7'h34, 7'h24, 1'b0, 7'h00};
         6'h06: s = '{1'b1, 7'h35, 7'h25, 1'b0, 7'h00};
         6'h07: s = '{1'b1, 7'h36, 7'h5E, 1'b1, 7'h1E};
         6'h08: s = '{1'b1, 7'h37, 7'h26, 1'b0, 7'h00};
         6'h09: s = '{1'b1, 7'h38, 7'h2A, 1'b0, 7'h00};
         6'h0A: s = '{1'b1, 7'h39, 7'h28, 1'b0, 7'h00};
         6'h0B: s = '{1'b1, 7'h30, 7'h29, 1'b0, 7'h00};
         6'h0C: s = '{1'b1, 7'h2D, 7'h5F, 1'b1, 7'h1F};
         6'h0D: s = '{1'b1, 7'h3D, 7'h2B, 1'b0, 7'h00};
         6'h1A: s = '{1'b1, 7'h5B, 7'h7B, 1'b1, 7'h1B};
         6'h1B: s = '{1'b1, 7'h5D, 7'h7D, 1'b1, 7'h1D};
         6'h27: s = '{1'b1, 7'h3B, 7'h3A, 1'b0, 7'h00};
         6'h28: s = '{1'b1, 7'h27, 7'h22, 1'b0, 7'h00}; // shifted apostrophe -> dquote
         6'h29: s = '{1'b1, 7'h60, 7'h7E, 1'b0, 7'h00};
         6'h2B: s = '{1'b1, 7'h5C, 7'h7C, 1'b1, 7'h1C};
         6'h33: s = '{1'b1, 7'h2C, 7'h3C, 1'b0, 7'h00};
         6'h34: s = '{1'b1, 7'h2E, 7'h3E, 1'b0, 7'h00};
         default: s = '0;
      endcase
      return s;
   endfunction

endpackage

// ----- rtl/kbsc_if.sv -----
// ---------------------------------------------------------------------------
// kbsc_req_if / kbsc_rsp_if
// Valid/ready channels carrying scan code words in and character words out.
// ---------------------------------------------------------------------------
interface kbsc_req_if;
   logic                         valid;
   logic                         ready;
   logic [kbsc_pkg::CODE_W-1:0]  scan_code;

   modport source (output valid, output scan_code, input ready);
   modport sink   (input valid, input scan_code, output ready);
endinterface

interface kbsc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         char_valid;
   logic [kbsc_pkg::CHAR_W-1:0]  char_code;
   logic                         reboot_request;

   modport source (output valid, output char_valid, output char_code,
                   output reboot_request, input ready);
   modport sink   (input valid, input char_valid, input char_code,
                   input reboot_request, output ready);
endinterface

// ----- rtl/keyboard_scancode_to_ascii_core.sv -----
// ---------------------------------------------------------------------------
// keyboard_scancode_to_ascii_core
// Set-1 scan code to ASCII decoder with modifier and ctrl-alt-del tracking.
// ---------------------------------------------------------------------------
// Usage:
//   req_if carries one scan code word per handshake; rsp_if returns exactly
//   one word per scan code: char_valid/char_code for a produced character
//   and reboot_request on the third and later Del make while ctrl and alt
//   stay held; a Del break clears the count. From acceptance, the code lands
//   in an input register, is decoded against the modifier/pause state, and
//   the result goes into the output register while the state updates.
//   Throughput is one word per cycle while rsp_if.ready is high; decode and
//   state update are a single short table lookup between the two registers.
//   When rsp_if.ready is low, the result holds in the output register and
//   one more code can still be taken into the input register; req_if.ready
//   drops only when both are full.
//   Reset empties both registers and clears ctrl, shift and alt state, the
//   Del press count and pause sequence tracking.
// ---------------------------------------------------------------------------
module keyboard_scancode_to_ascii_core (
   input  logic             clock,
   input  logic             reset,
   kbsc_req_if.sink         req_if,
   kbsc_rsp_if.source       rsp_if
);

   localparam logic [1:0] DEL_COUNT_MAX = 2'd3;

   // input stage
   logic                        s1_valid_ff;
   logic [kbsc_pkg::CODE_W-1:0] s1_code_ff;
   logic                        s1_move;

   // decoder state
   logic       ctrl_ff, ctrl_in;
   logic       shift_ff, shift_in;
   logic       alt_ff, alt_in;
   logic [1:0] del_cnt_ff, del_cnt_in;
   logic [2:0] pause_idx_ff, pause_idx_in;

   // output stage
   logic                        rsp_valid_ff;
   logic                        char_valid_ff, char_valid_in;
   logic [kbsc_pkg::CHAR_W-1:0] char_code_ff, char_code_in;
   logic                        reboot_ff, reboot_in;

   kbsc_pkg::kbsc_mods_type     mods;
   logic                        map_valid;
   logic [kbsc_pkg::CHAR_W-1:0] map_code;
   logic                        in_pause;

   assign s1_move      = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || s1_move;

   assign mods.ctrl  = ctrl_ff;
   assign mods.shift = shift_ff;

   kbsc_char_map u_char_map (
      .code       (s1_code_ff),
      .mods       (mods),
      .char_valid (map_valid),
      .char_code  (map_code)
   );

   assign in_pause = (pause_idx_ff != 3'd0) && (pause_idx_ff <= kbsc_pkg::PAUSE_TAIL_LEN);

   always_comb begin
      ctrl_in       = ctrl_ff;
      shift_in      = shift_ff;
      alt_in        = alt_ff;
      del_cnt_in    = del_cnt_ff;
      pause_idx_in  = '0;
      char_valid_in = 1'b0;
      char_code_in  = '0;
      reboot_in     = 1'b0;
      if (in_pause) begin
         // swallow the pause tail; any mismatch drops back to normal decode
         if ((s1_code_ff == kbsc_pkg::pause_byte(pause_idx_ff)) &&
             (pause_idx_ff < kbsc_pkg::PAUSE_TAIL_LEN)) begin
            pause_idx_in = pause_idx_ff + 3'd1;
         end
      end else begin
         unique case (s1_code_ff)
            kbsc_pkg::SC_EXT_PREFIX: begin
            end
            kbsc_pkg::SC_PAUSE_PREFIX: begin
               pause_idx_in = 3'd1;
            end
            kbsc_pkg::SC_CTRL_MAKE: begin
               ctrl_in = 1'b1;
            end
            kbsc_pkg::SC_CTRL_BREAK: begin
               ctrl_in    = 1'b0;
               del_cnt_in = '0;
            end
            kbsc_pkg::SC_LSHIFT_MAKE,
            kbsc_pkg::SC_RSHIFT_MAKE: begin
               shift_in = 1'b1;
            end
            kbsc_pkg::SC_LSHIFT_BREAK,
            kbsc_pkg::SC_RSHIFT_BREAK: begin
               shift_in = 1'b0;
            end
            kbsc_pkg::SC_ALT_MAKE: begin
               alt_in = 1'b1;
            end
            kbsc_pkg::SC_ALT_BREAK: begin
               alt_in     = 1'b0;
               del_cnt_in = '0;
            end
            kbsc_pkg::SC_DEL_MAKE: begin
               if (ctrl_ff && alt_ff) begin
                  if (del_cnt_ff != DEL_COUNT_MAX) begin
                     del_cnt_in = del_cnt_ff + 2'd1;
                  end
                  reboot_in = (del_cnt_in == DEL_COUNT_MAX);
               end
            end
            kbsc_pkg::SC_DEL_BREAK: begin
               del_cnt_in = '0;
            end
            default: begin
               char_valid_in = map_valid;
               char_code_in  = map_code;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ctrl_ff      <= 1'b0;
         shift_ff     <= 1'b0;
         alt_ff       <= 1'b0;
         del_cnt_ff   <= '0;
         pause_idx_ff <= '0;
      end else begin
         if (req_if.ready) begin
            s1_valid_ff <= req_if.valid;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
            ctrl_ff      <= ctrl_in;
            shift_ff     <= shift_in;
            alt_ff       <= alt_in;
            del_cnt_ff   <= del_cnt_in;
            pause_idx_ff <= pause_idx_in;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         s1_code_ff <= req_if.scan_code;
      end
      if (s1_move) begin
         char_valid_ff <= char_valid_in;
         char_code_ff  <= char_code_in;
         reboot_ff     <= reboot_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.char_valid     = char_valid_ff;
   assign rsp_if.char_code      = char_code_ff;
   assign rsp_if.reboot_request = reboot_ff;

endmodule

// ----- rtl/kbsc_char_map.sv -----
// ---------------------------------------------------------------------------
// kbsc_char_map
// Maps a make code plus ctrl/shift state to an ASCII character.
// ---------------------------------------------------------------------------
module kbsc_char_map (
   input  logic [kbsc_pkg::CODE_W-1:0] code,
   input  kbsc_pkg::kbsc_mods_type     mods,
   output logic                        char_valid,
   output logic [kbsc_pkg::CHAR_W-1:0] char_code
);

   logic [kbsc_pkg::CHAR_W-1:0] letter;
   kbsc_pkg::kbsc_sym_type      sym;

   assign letter = kbsc_pkg::letter_of(code[5:0]);
   assign sym    = kbsc_pkg::symbol_of(code[5:0]);

   always_comb begin
      char_valid = 1'b1;
      char_code  = '0;
      priority if (code == kbsc_pkg::SC_BACKSPACE) begin
         char_code = mods.ctrl ? 7'h7F : 7'h08;
      end else if (code == kbsc_pkg::SC_ENTER) begin
         char_code = mods.ctrl ? 7'h0A : 7'h0D;
      end else if (code == kbsc_pkg::SC_ESCAPE) begin
         char_code = 7'h1B;
      end else if (code == kbsc_pkg::SC_SPACE) begin
         char_code = 7'h20;
      end else if (code == kbsc_pkg::SC_TAB) begin
         char_code = 7'h09;
      end else if (code[7:6] != 2'b00) begin
         char_valid = 1'b0;
      end else if (letter != '0) begin
         // ctrl wins over shift
         if (mods.ctrl) begin
            char_code = {2'b00, letter[4:0]};
         end else if (mods.shift) begin
            char_code = letter - 7'h20;
         end else begin
            char_code = letter;
         end
      end else if (sym.present) begin
         if (mods.ctrl) begin
            char_valid = sym.ctrl_ok;
            char_code  = sym.ctrl_ok ? sym.ctrl_char : '0;
         end else if (mods.shift) begin
            char_code = sym.shifted;
         end else begin
            char_code = sym.plain;
         end
      end else begin
         char_valid = 1'b0;
      end
   end

endmodule

// ----- rtl/kbsc_checker.sv -----
// ---------------------------------------------------------------------------
// kbsc_checker
// Port-level checks for the scan code decoder, bound to the top level.
// ---------------------------------------------------------------------------
module kbsc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        char_valid,
   input logic [kbsc_pkg::CHAR_W-1:0] char_code,
   input logic                        reboot_request
);

   // no character means a zero code
   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !char_valid) |-> (char_code == '0))
      else $error("char_code nonzero without char_valid");

   // reboot comes from a Del make, which never yields a character
   a_reboot_no_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && reboot_request) |-> !char_valid)
      else $error("reboot_request together with a character");

   // an accepted code reaches rsp_valid when the receiver keeps up
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)
      else $error("result missing two cycles after accept");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(char_valid) && $stable(char_code) &&
          $stable(reboot_request)))
      else $error("stalled result changed");

endmodule

bind keyboard_scancode_to_ascii_core kbsc_checker u_kbsc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .char_valid     (rsp_if.char_valid),
   .char_code      (rsp_if.char_code),
   .reboot_request (rsp_if.reboot_request)
);
